// ----- sv/sose_pkg.sv -----
// shared types, constants and tables for the slater orbital shell evaluator
`default_nettype none
package sose_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int EXP_BITS   = 56;
  localparam int COS_BITS   = 30;
  localparam int EXP_SHIFT  = EXP_BITS - FRAC_BITS;
  localparam int NORM_SHIFT = FRAC_BITS - 16;

  localparam int IN_DATA_W  = 264;
  localparam int IN_USED_W  = 259;
  localparam int OUT_DATA_W = 40;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [63:0] EXP_LIMIT = 64'd64 << FRAC_BITS;
  localparam logic [63:0] EXP_ONE   = 64'd1 << EXP_BITS;
  localparam logic [5:0]  SH_FRAC   = 6'(FRAC_BITS);
  localparam logic [5:0]  SH_EXP    = 6'(EXP_BITS);
  localparam logic [5:0]  SH_RECIP  = 6'd60;
  localparam logic [3:0]  TAYLOR_LAST = 4'd7;
  localparam logic [3:0]  SQUARE_LAST = 4'd11;

  localparam logic [32:0] K_S = 33'd1211587905;
  localparam logic [30:0] K_P = 31'd2098531809;

  localparam logic [1:0] AX_X    = 2'd0;
  localparam logic [1:0] AX_Y    = 2'd1;
  localparam logic [1:0] AX_Z    = 2'd2;
  localparam logic [1:0] AX_NONE = 2'd3;

  typedef enum logic [1:0] {
    ANG_S = 2'd0,
    ANG_P = 2'd1,
    ANG_D = 2'd2,
    ANG_F = 2'd3
  } ang_t;

  typedef struct packed {
    logic [63:0]       radial;
    logic [2:0][30:0]  cosv;
    logic [2:0]        neg;
    logic              zero;
    ang_t              ang;
  } job_t;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_OFFSET,
    FS_SQUARE,
    FS_SQRT,
    FS_AR,
    FS_TAY_MUL,
    FS_TAY_DIV,
    FS_SQR,
    FS_NORM,
    FS_POW,
    FS_COS,
    FS_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_M1,
    BS_M2,
    BS_LO,
    BS_HI,
    BS_FIN
  } back_state_t;

  function automatic logic [3:0] shell_count(ang_t l);
    logic [3:0] c;
    case (l)
      ANG_S:   c = 4'd1;
      ANG_P:   c = 4'd3;
      ANG_D:   c = 4'd6;
      ANG_F:   c = 4'd10;
      default: c = 4'd1;
    endcase
    return c;
  endfunction

  // ceil(2^60 / (c + 1)), exact floor division for taylor terms below 2^57
  function automatic logic [63:0] recip(logic [3:0] c);
    logic [63:0] m;
    case (c)
      4'd0:    m = 64'h1000_0000_0000_0000;
      4'd1:    m = 64'h0800_0000_0000_0000;
      4'd2:    m = 64'h0555_5555_5555_5556;
      4'd3:    m = 64'h0400_0000_0000_0000;
      4'd4:    m = 64'h0333_3333_3333_3334;
      4'd5:    m = 64'h02AA_AAAA_AAAA_AAAB;
      4'd6:    m = 64'h0249_2492_4924_924A;
      4'd7:    m = 64'h0200_0000_0000_0000;
      default: m = 64'h1000_0000_0000_0000;
    endcase
    return m;
  endfunction

  // axes packed as {third, second, first}
  function automatic logic [5:0] shell_axes(ang_t l, logic [3:0] k);
    logic [5:0] a;
    a = {AX_NONE, AX_NONE, AX_NONE};
    case (l)
      ANG_P: begin
        case (k)
          4'd0:    a = {AX_NONE, AX_NONE, AX_X};
          4'd1:    a = {AX_NONE, AX_NONE, AX_Y};
          4'd2:    a = {AX_NONE, AX_NONE, AX_Z};
          default: a = {AX_NONE, AX_NONE, AX_NONE};
        endcase
      end
      ANG_D: begin
        case (k)
          4'd0:    a = {AX_NONE, AX_X, AX_X};
          4'd1:    a = {AX_NONE, AX_Y, AX_X};
          4'd2:    a = {AX_NONE, AX_Z, AX_X};
          4'd3:    a = {AX_NONE, AX_Y, AX_Y};
          4'd4:    a = {AX_NONE, AX_Z, AX_Y};
          4'd5:    a = {AX_NONE, AX_Z, AX_Z};
          default: a = {AX_NONE, AX_NONE, AX_NONE};
        endcase
      end
      ANG_F: begin
        case (k)
          4'd0:    a = {AX_X, AX_X, AX_X};
          4'd1:    a = {AX_Y, AX_X, AX_X};
          4'd2:    a = {AX_Z, AX_X, AX_X};
          4'd3:    a = {AX_Y, AX_Y, AX_X};
          4'd4:    a = {AX_Z, AX_Y, AX_X};
          4'd5:    a = {AX_Z, AX_Z, AX_X};
          4'd6:    a = {AX_Y, AX_Y, AX_Y};
          4'd7:    a = {AX_Z, AX_Y, AX_Y};
          4'd8:    a = {AX_Z, AX_Z, AX_Y};
          4'd9:    a = {AX_Z, AX_Z, AX_Z};
          default: a = {AX_NONE, AX_NONE, AX_NONE};
        endcase
      end
      default: a = {AX_NONE, AX_NONE, AX_NONE};
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- sv/slater_orbital_shell_eval.sv -----
// slater-type orbital shell evaluator, top level
// in_* takes one shell/point pair per beat and out_* returns one cartesian
// component per beat: 1 for s, 3 for p, 6 for d, 10 for f, tlast on the last
// one and tuser set when the point sits on the centre for p, d or f.
// an input buffer takes a beat while the previous one is still worked on,
// so in_tready drops only while a beat waits there.
// the front sequencer's time per shell grows with the radial power N and
// is shorter when the point sits on the centre or when decay times
// distance reaches 64; it is set by the 64-step divider used three times
// for the direction cosines and the four-pass shared multiplier used in
// the exponential.
// a two-entry job queue decouples it from the emitter, which steps through
// BS_M1, BS_M2, BS_LO, BS_HI and BS_FIN for each component.
// reset (rst_n low, synchronous) empties the buffer, queue and output
// register; a stalled out_tready holds the output register, then the
// emitter, then the queue and finally the front sequencer
`default_nettype none
module slater_orbital_shell_eval (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // point_x, point_y, point_z, center_x, center_y, center_z,
  // decay_exponent, radial_scale, radial_power, zero pad
  input  logic [sose_pkg::IN_DATA_W-1:0]  in_tdata,
  // ang_mom
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // orbital_value, component, zero pad
  output logic [sose_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  // zero_distance
  output logic                            out_tuser
);

  sose_pkg::job_t q_job, q_head;
  logic           q_push, q_pop, q_full, q_empty;

  sose_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  sose_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .job_in (q_job),
    .pop    (q_pop),
    .full   (q_full),
    .empty  (q_empty),
    .head   (q_head)
  );

  sose_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("job queue read while empty");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[31:0] == 32'd0)
    else $error("component on the centre is not zero");

  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[35:32] <= 4'd9)
    else $error("component index out of range");

endmodule
`default_nettype wire

// ----- sv/sose_mul.sv -----
// shared 64x64 multiplier with right shift and saturation, four 32x32 passes
`default_nettype none
module sose_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [5:0]  shift,
  output logic        done,
  output logic [63:0] result
);

  logic [63:0]  a_r, b_r, result_r;
  logic [5:0]   sh_r;
  logic [127:0] prod_r, prod_nxt, part_sh, shifted;
  logic [2:0]   step_r;
  logic         busy_r, done_r;
  logic [31:0]  pa, pb;
  logic [63:0]  part;

  always_comb begin
    case (step_r[1:0])
      2'd0: begin
        pa = a_r[31:0];
        pb = b_r[31:0];
      end
      2'd1: begin
        pa = a_r[31:0];
        pb = b_r[63:32];
      end
      2'd2: begin
        pa = a_r[63:32];
        pb = b_r[31:0];
      end
      default: begin
        pa = a_r[63:32];
        pb = b_r[63:32];
      end
    endcase
    part = 64'(pa) * 64'(pb);
    case (step_r[1:0])
      2'd0:    part_sh = {64'd0, part};
      2'd1:    part_sh = {32'd0, part, 32'd0};
      2'd2:    part_sh = {32'd0, part, 32'd0};
      default: part_sh = {part, 64'd0};
    endcase
    prod_nxt = prod_r + part_sh;
    shifted  = prod_r >> sh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        if (step_r == 3'd4) begin
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      b_r    <= b;
      sh_r   <= shift;
      prod_r <= '0;
    end else if (busy_r) begin
      if (step_r == 3'd4) begin
        result_r <= (|shifted[127:64]) ? '1 : shifted[63:0];
      end else begin
        prod_r <= prod_nxt;
      end
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule
`default_nettype wire

// ----- sv/sose_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none
module sose_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] rem_r, quo_r, den_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [64:0] trial;
  logic        ge;

  assign trial = {rem_r, quo_r[63]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? 64'(trial - {1'b0, den_r}) : trial[63:0];
      quo_r <= {quo_r[62:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ----- sv/sose_front.sv -----
// front end: input buffer and radial/direction sequencer feeding the job queue
`default_nettype none
module sose_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sose_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]                     in_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output sose_pkg::job_t                 q_job
);

  sose_pkg::front_state_t state_r, state_nxt;

  logic                           ibuf_valid_r;
  logic [sose_pkg::IN_USED_W-1:0] ibuf_data_r;
  logic [1:0]                     ibuf_ang_r;
  logic                           accept, started_r;

  logic [31:0]       a_r, s_r;
  logic [2:0]        n_r;
  sose_pkg::ang_t    l_r;
  logic [2:0][31:0]  dm_r;
  logic [2:0]        neg_r;
  logic              sh2_r, zero_r;
  logic [63:0]       sum_r, v_r, res_r, bit_r, r_r, y_r, term_r, esum_r, t_r;
  logic [2:0][30:0]  cos_r;
  logic [3:0]        cnt_r;

  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b, mul_res, div_num, div_den, div_q;
  logic [5:0]  mul_sh;

  logic [2:0][32:0] diff;
  logic [2:0][31:0] mag, dm_new;
  logic [2:0]       neg_new;
  logic             sh2_new;
  logic [31:0]      dm_cur;
  logic [63:0]      sq, resbit, res_step, rs_shifted;
  logic             sqrt_ge, sqrt_last, pow_last, exp_big;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !ibuf_valid_r;

  // offsets and magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {ibuf_data_r[32*i+31], ibuf_data_r[32*i +: 32]}
              - {ibuf_data_r[32*i+127], ibuf_data_r[32*i+96 +: 32]};
      neg_new[i] = diff[i][32];
      mag[i]     = neg_new[i] ? 32'(-diff[i]) : diff[i][31:0];
    end
    sh2_new = mag[0][31] || mag[1][31] || mag[2][31];
    for (int i = 0; i < 3; i++) begin
      dm_new[i] = sh2_new ? (mag[i] >> 2) : mag[i];
    end
  end

  always_comb begin
    dm_cur     = dm_r[cnt_r[1:0]];
    sq         = 64'(dm_cur) * 64'(dm_cur);
    resbit     = res_r + bit_r;
    sqrt_ge    = v_r >= resbit;
    res_step   = sqrt_ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
    sqrt_last  = bit_r == 64'd1;
    rs_shifted = sh2_r ? (res_step << 2) : res_step;
    pow_last   = (cnt_r + 4'd1) == {1'b0, n_r};
    exp_big    = mul_res >= sose_pkg::EXP_LIMIT;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sose_pkg::FS_IDLE:
        if (ibuf_valid_r) state_nxt = sose_pkg::FS_OFFSET;
      sose_pkg::FS_OFFSET:
        state_nxt = sose_pkg::FS_SQUARE;
      sose_pkg::FS_SQUARE:
        if (cnt_r == 4'd2) state_nxt = sose_pkg::FS_SQRT;
      sose_pkg::FS_SQRT:
        if (sqrt_last) state_nxt = sose_pkg::FS_AR;
      sose_pkg::FS_AR:
        if (mul_done) state_nxt = exp_big ? sose_pkg::FS_NORM : sose_pkg::FS_TAY_MUL;
      sose_pkg::FS_TAY_MUL:
        if (mul_done) state_nxt = sose_pkg::FS_TAY_DIV;
      sose_pkg::FS_TAY_DIV:
        if (mul_done) begin
          state_nxt = (cnt_r == sose_pkg::TAYLOR_LAST) ? sose_pkg::FS_SQR
                                                       : sose_pkg::FS_TAY_MUL;
        end
      sose_pkg::FS_SQR:
        if (mul_done && cnt_r == sose_pkg::SQUARE_LAST) state_nxt = sose_pkg::FS_NORM;
      sose_pkg::FS_NORM:
        if (mul_done) state_nxt = (n_r == 3'd0) ? sose_pkg::FS_COS : sose_pkg::FS_POW;
      sose_pkg::FS_POW:
        if (mul_done && pow_last) state_nxt = sose_pkg::FS_COS;
      sose_pkg::FS_COS:
        if (zero_r || (div_done && cnt_r == 4'd2)) state_nxt = sose_pkg::FS_PUSH;
      sose_pkg::FS_PUSH:
        if (!q_full) state_nxt = sose_pkg::FS_IDLE;
      default:
        state_nxt = sose_pkg::FS_IDLE;
    endcase
  end

  // unit control and operands
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = t_r;
    mul_b     = r_r;
    mul_sh    = sose_pkg::SH_FRAC;
    div_num   = 64'(dm_cur) << sose_pkg::COS_BITS;
    div_den   = res_r;
    q_push    = 1'b0;
    case (state_r)
      sose_pkg::FS_AR: begin
        mul_start = !started_r;
        mul_a     = {32'd0, a_r};
      end
      sose_pkg::FS_TAY_MUL: begin
        mul_start = !started_r;
        mul_a     = term_r;
        mul_b     = y_r;
        mul_sh    = sose_pkg::SH_EXP;
      end
      sose_pkg::FS_TAY_DIV: begin
        mul_start = !started_r;
        mul_a     = term_r;
        mul_b     = sose_pkg::recip(cnt_r);
        mul_sh    = sose_pkg::SH_RECIP;
      end
      sose_pkg::FS_SQR: begin
        mul_start = !started_r;
        mul_a     = esum_r;
        mul_b     = esum_r;
        mul_sh    = sose_pkg::SH_EXP;
      end
      sose_pkg::FS_NORM: begin
        mul_start = !started_r;
        mul_a     = {32'd0, s_r} << sose_pkg::NORM_SHIFT;
        mul_b     = esum_r >> sose_pkg::EXP_SHIFT;
      end
      sose_pkg::FS_POW:
        mul_start = !started_r;
      sose_pkg::FS_COS:
        div_start = !started_r && !zero_r;
      sose_pkg::FS_PUSH:
        q_push = !q_full;
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sose_pkg::FS_IDLE;
      ibuf_valid_r <= 1'b0;
      started_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) ibuf_valid_r <= 1'b1;
      else if (state_r == sose_pkg::FS_OFFSET) ibuf_valid_r <= 1'b0;
      if (mul_start || div_start) started_r <= 1'b1;
      else if (mul_done || div_done) started_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ibuf_data_r <= in_tdata[sose_pkg::IN_USED_W-1:0];
      ibuf_ang_r  <= in_tuser;
    end
    case (state_r)
      sose_pkg::FS_OFFSET: begin
        a_r    <= ibuf_data_r[223:192];
        s_r    <= ibuf_data_r[255:224];
        n_r    <= ibuf_data_r[258:256];
        l_r    <= sose_pkg::ang_t'(ibuf_ang_r);
        dm_r   <= dm_new;
        neg_r  <= neg_new;
        sh2_r  <= sh2_new;
        cos_r  <= '0;
        sum_r  <= '0;
        cnt_r  <= 4'd0;
      end
      sose_pkg::FS_SQUARE: begin
        sum_r <= sum_r + sq;
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd2) begin
          v_r   <= sum_r + sq;
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      sose_pkg::FS_SQRT: begin
        if (sqrt_ge) v_r <= v_r - resbit;
        res_r <= res_step;
        bit_r <= bit_r >> 2;
        if (sqrt_last) begin
          r_r    <= rs_shifted;
          zero_r <= res_step == 64'd0;
        end
      end
      sose_pkg::FS_AR: begin
        if (mul_done) begin
          cnt_r <= 4'd0;
          if (exp_big) begin
            esum_r <= '0;
          end else begin
            y_r    <= (mul_res << sose_pkg::EXP_SHIFT) >> 12;
            term_r <= sose_pkg::EXP_ONE;
            esum_r <= sose_pkg::EXP_ONE;
          end
        end
      end
      sose_pkg::FS_TAY_MUL: begin
        if (mul_done) term_r <= mul_res;
      end
      sose_pkg::FS_TAY_DIV: begin
        if (mul_done) begin
          term_r <= mul_res;
          esum_r <= cnt_r[0] ? (esum_r + mul_res) : (esum_r - mul_res);
          cnt_r  <= (cnt_r == sose_pkg::TAYLOR_LAST) ? 4'd0 : (cnt_r + 4'd1);
        end
      end
      sose_pkg::FS_SQR: begin
        if (mul_done) begin
          esum_r <= mul_res;
          cnt_r  <= cnt_r + 4'd1;
        end
      end
      sose_pkg::FS_NORM: begin
        if (mul_done) begin
          t_r   <= mul_res;
          cnt_r <= 4'd0;
        end
      end
      sose_pkg::FS_POW: begin
        if (mul_done) begin
          t_r   <= mul_res;
          cnt_r <= pow_last ? 4'd0 : (cnt_r + 4'd1);
        end
      end
      sose_pkg::FS_COS: begin
        if (div_done) begin
          cos_r[cnt_r[1:0]] <= div_q[30:0];
          cnt_r <= cnt_r + 4'd1;
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  sose_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .shift  (mul_sh),
    .done   (mul_done),
    .result (mul_res)
  );

  sose_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_job.radial = t_r;
  assign q_job.cosv   = cos_r;
  assign q_job.neg    = neg_r;
  assign q_job.zero   = zero_r;
  assign q_job.ang    = l_r;

endmodule
`default_nettype wire

// ----- sv/sose_fifo.sv -----
// short job queue between the front sequencer and the component emitter
`default_nettype none
module sose_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sose_pkg::job_t job_in,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output sose_pkg::job_t head
);

  sose_pkg::job_t               mem_r [sose_pkg::Q_DEPTH];
  logic [sose_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [sose_pkg::Q_CNT_W-1:0] cnt_r;

  assign full  = cnt_r == sose_pkg::Q_CNT_W'(sose_pkg::Q_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= job_in;
  end

endmodule
`default_nettype wire

// ----- sv/sose_back.sv -----
// back end: angular factors, scaling, saturation and the result register
`default_nettype none
module sose_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  sose_pkg::job_t                  q_head,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sose_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic                            out_tuser
);

  sose_pkg::back_state_t state_r, state_nxt;

  logic [3:0]  k_r;
  logic [31:0] m1_r;
  logic [32:0] g_r, g_nxt;
  logic [64:0] plo_r, phi_r;
  logic        out_valid_r, out_last_r, out_zd_r;
  logic [31:0] out_val_r;
  logic [3:0]  out_comp_r;

  logic [5:0]  axes;
  logic [30:0] c0, c1, c2, mb;
  logic [61:0] prod1, prod2;
  logic [65:0] vfull;
  logic [31:0] res;
  logic        sgn, last, zd, vzero, big, out_load;

  function automatic logic [30:0] cos_pick(sose_pkg::job_t j, logic [1:0] ax);
    logic [30:0] c;
    case (ax)
      sose_pkg::AX_X: c = j.cosv[0];
      sose_pkg::AX_Y: c = j.cosv[1];
      sose_pkg::AX_Z: c = j.cosv[2];
      default:        c = '0;
    endcase
    return c;
  endfunction

  function automatic logic neg_pick(sose_pkg::job_t j, logic [1:0] ax);
    logic n;
    case (ax)
      sose_pkg::AX_X: n = j.neg[0];
      sose_pkg::AX_Y: n = j.neg[1];
      sose_pkg::AX_Z: n = j.neg[2];
      default:        n = 1'b0;
    endcase
    return n;
  endfunction

  always_comb begin
    axes  = sose_pkg::shell_axes(q_head.ang, k_r);
    c0    = cos_pick(q_head, axes[1:0]);
    c1    = cos_pick(q_head, axes[3:2]);
    c2    = cos_pick(q_head, axes[5:4]);
    mb    = (q_head.ang == sose_pkg::ANG_P) ? sose_pkg::K_P : c1;
    prod1 = 62'(c0) * 62'(mb);
    prod2 = 62'(m1_r[30:0]) * 62'(c2);
    case (q_head.ang)
      sose_pkg::ANG_S: g_nxt = sose_pkg::K_S;
      sose_pkg::ANG_P: g_nxt = {1'b0, m1_r};
      sose_pkg::ANG_D: g_nxt = {m1_r[30:0], 2'b00};
      default:         g_nxt = {prod2[60:30], 2'b00};
    endcase
    if (q_head.zero && q_head.ang != sose_pkg::ANG_S) g_nxt = '0;
    sgn = neg_pick(q_head, axes[1:0]) ^ neg_pick(q_head, axes[3:2])
        ^ neg_pick(q_head, axes[5:4]);
    vfull = {1'b0, phi_r} + {33'd0, plo_r[64:32]};
    vzero = vfull == '0;
    big   = |vfull[65:31];
    if (vzero)    res = '0;
    else if (!sgn) res = big ? 32'h7FFF_FFFF : vfull[31:0];
    else          res = big ? 32'h8000_0000 : 32'(-vfull[31:0]);
    last = (k_r + 4'd1) == sose_pkg::shell_count(q_head.ang);
    zd   = q_head.zero && q_head.ang != sose_pkg::ANG_S;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sose_pkg::BS_IDLE: if (!q_empty) state_nxt = sose_pkg::BS_M1;
      sose_pkg::BS_M1:   state_nxt = sose_pkg::BS_M2;
      sose_pkg::BS_M2:   state_nxt = sose_pkg::BS_LO;
      sose_pkg::BS_LO:   state_nxt = sose_pkg::BS_HI;
      sose_pkg::BS_HI:   state_nxt = sose_pkg::BS_FIN;
      sose_pkg::BS_FIN:
        if (out_load) state_nxt = last ? sose_pkg::BS_IDLE : sose_pkg::BS_M1;
      default: state_nxt = sose_pkg::BS_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    out_load = 1'b0;
    case (state_r)
      sose_pkg::BS_FIN: out_load = !out_valid_r || out_tready;
      default:          out_load = 1'b0;
    endcase
    q_pop = out_load && last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sose_pkg::BS_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= 4'd0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (state_r == sose_pkg::BS_IDLE) k_r <= 4'd0;
      else if (out_load) k_r <= k_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      sose_pkg::BS_M1: m1_r  <= prod1[61:30];
      sose_pkg::BS_M2: g_r   <= g_nxt;
      sose_pkg::BS_LO: plo_r <= 65'(q_head.radial[31:0]) * 65'(g_r);
      sose_pkg::BS_HI: phi_r <= 65'(q_head.radial[63:32]) * 65'(g_r);
      default:         m1_r  <= m1_r;
    endcase
    if (out_load) begin
      out_val_r  <= res;
      out_comp_r <= k_r;
      out_last_r <= last;
      out_zd_r   <= zd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_comp_r, out_val_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_zd_r;

endmodule
`default_nettype wire

// ----- verif/tb_slater_orbital_shell_eval.sv -----
// testbench for the slater orbital shell evaluator: a self-checking stream driver and monitor
`timescale 1ns / 1ps
module tb_slater_orbital_shell_eval;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 2000;
  localparam int RANDOM_SHELLS = 210;

  typedef struct {
    logic [31:0]     px, py, pz, cx, cy, cz;
    logic [31:0]     decay, scale;
    logic [2:0]      power;
    sose_pkg::ang_t  ang;
  } shell_t;

  typedef struct {
    logic [31:0] value;
    logic [3:0]  comp;
    logic        last;
    logic        zd;
  } comp_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tlast, out_tuser;
  logic [sose_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [1:0]                      in_tuser;
  logic [sose_pkg::OUT_DATA_W-1:0] out_tdata;

  shell_t pending_shells[$];
  comp_t  exp_components[$];
  int     mismatches = 0;
  int     cycles = 0;

  slater_orbital_shell_eval dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = a * b;
    if ((p >> (64 + sh)) != 0) return '1;
    return 64'(p >> sh);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] decay_factor(logic [63:0] x);
    logic [63:0] y, term, acc;
    if (x >= (64'd64 << sose_pkg::FRAC_BITS)) return 0;
    y = (x << (sose_pkg::EXP_BITS - sose_pkg::FRAC_BITS)) >> 12;
    term = 64'd1 << sose_pkg::EXP_BITS;
    acc = term;
    for (int k = 1; k <= 8; k++) begin
      term = mul_sat(term, y, sose_pkg::EXP_BITS) / k;
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    for (int k = 0; k < 12; k++) acc = mul_sat(acc, acc, sose_pkg::EXP_BITS);
    return acc >> (sose_pkg::EXP_BITS - sose_pkg::FRAC_BITS);
  endfunction

  task automatic predict_shell(shell_t s);
    logic [63:0] mag[3], dm[3], cosv[3];
    logic        neg[3];
    logic [63:0] big, sq, rs, r, t, g, val, p;
    logic [31:0] res;
    logic [5:0]  axes;
    logic [1:0]  ax;
    logic [31:0] pt[3], ct[3];
    longint      d;
    int          sh, cnt, lval;
    logic        zero, sgn;
    comp_t       c;
    pt[0] = s.px; pt[1] = s.py; pt[2] = s.pz;
    ct[0] = s.cx; ct[1] = s.cy; ct[2] = s.cz;
    big = 0; sq = 0;
    for (int i = 0; i < 3; i++) begin
      d = longint'($signed(pt[i])) - longint'($signed(ct[i]));
      neg[i] = d < 0;
      mag[i] = neg[i] ? 64'(-d) : 64'(d);
      if (mag[i] > big) big = mag[i];
    end
    sh = (big >= (64'd1 << 31)) ? 2 : 0;
    for (int i = 0; i < 3; i++) begin
      dm[i] = mag[i] >> sh;
      sq = sq + dm[i] * dm[i];
      cosv[i] = 0;
    end
    rs = floor_sqrt(sq);
    r = rs << sh;
    zero = (rs == 0);
    lval = int'(s.ang);
    t = mul_sat(64'(s.scale) << (sose_pkg::FRAC_BITS - 16),
                decay_factor(mul_sat(64'(s.decay), r, sose_pkg::FRAC_BITS)),
                sose_pkg::FRAC_BITS);
    for (int i = 0; i < int'(s.power); i++) t = mul_sat(t, r, sose_pkg::FRAC_BITS);
    if (!zero)
      for (int i = 0; i < 3; i++) cosv[i] = (dm[i] << sose_pkg::COS_BITS) / rs;
    cnt = int'(sose_pkg::shell_count(s.ang));
    for (int k = 0; k < cnt; k++) begin
      sgn = 1'b0;
      if (s.ang == sose_pkg::ANG_S) begin
        g = 64'd1211587905;
      end else if (zero) begin
        g = 0;
      end else begin
        p = 64'd1 << sose_pkg::COS_BITS;
        axes = sose_pkg::shell_axes(s.ang, 4'(k));
        for (int i = 0; i < lval; i++) begin
          ax = axes[2*i +: 2];
          if (ax != sose_pkg::AX_NONE) begin
            p = (p * cosv[ax]) >> sose_pkg::COS_BITS;
            sgn = sgn ^ neg[ax];
          end
        end
        g = (s.ang == sose_pkg::ANG_P) ? ((p * 64'd2098531809) >> sose_pkg::COS_BITS)
                                       : (p << 2);
      end
      val = mul_sat(t, g, 32);
      if (val == 0) res = 0;
      else if (!sgn) res = (val > 64'h7FFFFFFF) ? 32'h7FFFFFFF : val[31:0];
      else res = (val >= 64'h80000000) ? 32'h80000000 : 32'(64'd0 - val);
      c.value = res;
      c.comp = 4'(k);
      c.last = (k + 1 == cnt);
      c.zd = zero && (s.ang != sose_pkg::ANG_S);
      exp_components.push_back(c);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  function automatic logic idle_now();
    if (cycles > 40000 && cycles < 120000) return 1'b0;
    return $urandom_range(99) < 29;
  endfunction

  // driver
  always @(posedge clk) begin
    shell_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !idle_now();
      if (!in_tvalid || in_tready) begin
        if (pending_shells.size() != 0 && !idle_now()) begin
          s = pending_shells.pop_front();
          in_tdata <= {5'd0, s.power, s.scale, s.decay, s.cz, s.cy, s.cx, s.pz, s.py, s.px};
          in_tuser <= s.ang;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    shell_t s;
    comp_t  c;
    cycles <= cycles + 1;
    if (rst_n && in_tvalid && in_tready) begin
      s.px = in_tdata[31:0];     s.py = in_tdata[63:32];   s.pz = in_tdata[95:64];
      s.cx = in_tdata[127:96];   s.cy = in_tdata[159:128]; s.cz = in_tdata[191:160];
      s.decay = in_tdata[223:192];
      s.scale = in_tdata[255:224];
      s.power = in_tdata[258:256];
      s.ang = sose_pkg::ang_t'(in_tuser);
      predict_shell(s);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_components.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[31:0], 32'd0);
      end else begin
        c = exp_components.pop_front();
        if (out_tdata[31:0] !== c.value) report_mismatch("value", out_tdata[31:0], c.value);
        if (out_tdata[35:32] !== c.comp) report_mismatch("component", out_tdata[35:32], c.comp);
        if (out_tdata[39:36] !== 4'd0) report_mismatch("pad", out_tdata[39:36], 0);
        if (out_tlast !== c.last) report_mismatch("tlast", out_tlast, c.last);
        if (out_tuser !== c.zd) report_mismatch("tuser", out_tuser, c.zd);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic shell_t near_shell();
    shell_t s;
    s.cx = $urandom(); s.cy = $urandom(); s.cz = $urandom();
    s.px = s.cx + 32'($signed($urandom_range(67108864)) - 33554432);
    s.py = s.cy + 32'($signed($urandom_range(67108864)) - 33554432);
    s.pz = s.cz + 32'($signed($urandom_range(67108864)) - 33554432);
    s.decay = $urandom_range(32'h0400_0000);
    s.scale = $urandom();
    s.power = 3'($urandom_range(3));
    if ($urandom_range(9) == 0) s.power = 3'($urandom_range(7));
    s.ang = sose_pkg::ang_t'($urandom_range(3));
    return s;
  endfunction

  function automatic shell_t noise_shell();
    shell_t s;
    s.px = $urandom(); s.py = $urandom(); s.pz = $urandom();
    s.cx = $urandom(); s.cy = $urandom(); s.cz = $urandom();
    s.decay = $urandom(); s.scale = $urandom();
    s.power = 3'($urandom_range(7));
    s.ang = sose_pkg::ang_t'($urandom_range(3));
    return s;
  endfunction

  initial begin
    shell_t s;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    out_tready = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    for (int l = 0; l < 4; l++) begin
      // regular shell, then point on centre with and without radial power
      s = near_shell(); s.ang = sose_pkg::ang_t'(l); s.power = 3'd1;
      pending_shells.push_back(s);
      s.px = s.cx; s.py = s.cy; s.pz = s.cz; s.power = 3'd0;
      pending_shells.push_back(s);
      s.power = 3'd2;
      pending_shells.push_back(s);
      // widest offsets, pre-shift path
      s = noise_shell(); s.ang = sose_pkg::ang_t'(l);
      s.px = 32'h7FFFFFFF; s.py = 32'h80000000; s.pz = 32'h7FFFFFFF;
      s.cx = 32'h80000000; s.cy = 32'h7FFFFFFF; s.cz = 32'h80000000;
      s.decay = 32'd0; s.scale = 32'hFFFFFFFF; s.power = 3'd7;
      pending_shells.push_back(s);
    end
    s = near_shell(); s.decay = 32'hFFFFFFFF; s.ang = sose_pkg::ANG_F;
    pending_shells.push_back(s);
    s = near_shell(); s.decay = 32'd0; s.scale = 32'hFFFFFFFF; s.ang = sose_pkg::ANG_D;
    s.power = 3'd7;
    pending_shells.push_back(s);
    s = near_shell(); s.scale = 32'd0; s.ang = sose_pkg::ANG_P;
    pending_shells.push_back(s);
    s = near_shell(); s.decay = 32'd1; s.scale = 32'd1; s.ang = sose_pkg::ANG_S;
    s.power = 3'd7;
    pending_shells.push_back(s);
    for (int i = 0; i < RANDOM_SHELLS; i++)
      pending_shells.push_back(($urandom_range(99) < 75) ? near_shell() : noise_shell());

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_shells.size() != 0 || in_tvalid) @(posedge clk);
    while (exp_components.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- slater_orbital_shell_eval.f -----
sv/sose_pkg.sv
sv/sose_mul.sv
sv/sose_div.sv
sv/sose_front.sv
sv/sose_fifo.sv
sv/sose_back.sv
sv/slater_orbital_shell_eval.sv
verif/tb_slater_orbital_shell_eval.sv
